// ----- hdl/psn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psn_pkg: shared types and constants for the programmable sorting network
// Holds the default sizes, the CSR map, the controller state type and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package psn_pkg;

   // default sizes
   localparam int WIRES_DEF           = 8;
   localparam int MAX_COMPARATORS_DEF = 24;
   localparam int VALUE_BITS_DEF      = 16;

   // CSR port and comparator table layout
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 48;
   localparam int COUNT_BITS      = 5;
   localparam int CFG_WORDS       = 3;
   localparam int PAIR_BITS       = 6;
   localparam int WIRE_FIELD_BITS = 3;
   localparam int PAIR_SEL_BITS   = 3;
   localparam int TABLE_IDX_BITS  = 5;

   // register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COUNT = 2'd0,
      CSR_WORD0 = 2'd1,
      CSR_WORD1 = 2'd2,
      CSR_WORD2 = 2'd3
   } csr_index_type;

   // controller states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_NET_ISSUE,
      ST_NET_CMP,
      ST_NET_SWAP,
      ST_ASC_RUN,
      ST_ASC_LAST,
      ST_EMIT
   } state_type;

   // store write source
   typedef enum logic [1:0] {
      WR_NONE,
      WR_LOAD,
      WR_LOW,
      WR_HIGH
   } wr_sel_type;

   // store read address source
   typedef enum logic [1:0] {
      RD_PAIR,
      RD_ADJ,
      RD_WIRE
   } rd_sel_type;

   typedef struct packed {
      wr_sel_type wr_sel;
      rd_sel_type rd_sel;
      logic       asc_init;
      logic       asc_check;
      logic       emit;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic pair_ok;
      logic net_done;
      logic greater;
   } status_type;

endpackage
`default_nettype wire

// ----- hdl/programmable_sorting_network.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// programmable_sorting_network: CSR-programmed compare-exchange network
// Loads WIRES signed words, applies the configured comparators in table
// order and returns the vector in wire order with last and ascending flags.
// ----------------------------------------------------------------------------
// Usage: pulse start with a word while busy is low; words land on wires 0,
// 1, 2 and so on. Loads are taken with busy low. The word that fills the
// last wire raises busy while the network runs on a two-read, one-write
// store: a comparator with a bad pair is skipped, one already in order is
// read and compared, and one that swaps also writes both wires back. Once
// the count is reached, an ascending check runs over the adjacent pairs, and
// the WIRES results follow, one per cycle, on rsp_valid. Results are not
// back-pressured: the receiver must take each word in the cycle rsp_valid is
// high. csr_ready is always high; CSRs are to be written only while the
// block is idle.
// ----------------------------------------------------------------------------
module programmable_sorting_network #(
   parameter int WIRES           = psn_pkg::WIRES_DEF,
   parameter int MAX_COMPARATORS = psn_pkg::MAX_COMPARATORS_DEF,
   parameter int VALUE_BITS      = psn_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input words
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [VALUE_BITS-1:0]      req_sample_value,
   // results
   output logic                                   rsp_valid,
   output logic signed [VALUE_BITS-1:0]           rsp_wire_value,
   output logic                                   rsp_last_of_vector,
   output logic                                   rsp_is_ascending,
   // CSR write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire psn_pkg::csr_index_type            csr_index,
   input  wire logic [psn_pkg::CSR_DATA_BITS-1:0] csr_data
);

   import psn_pkg::*;

   localparam int IDX_BITS = $clog2(WIRES);
   localparam int CMP_BITS = $clog2(MAX_COMPARATORS + 1);

   cmd_type             cmd;
   status_type          status;
   logic [IDX_BITS-1:0] wire_idx;
   logic [CMP_BITS-1:0] cmp_idx;

   assign csr_ready = 1'b1;

   psn_ctrl #(
      .WIRES           (WIRES),
      .MAX_COMPARATORS (MAX_COMPARATORS),
      .IDX_BITS        (IDX_BITS),
      .CMP_BITS        (CMP_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd),
      .wire_idx (wire_idx),
      .cmp_idx  (cmp_idx)
   );

   psn_datapath #(
      .WIRES           (WIRES),
      .MAX_COMPARATORS (MAX_COMPARATORS),
      .VALUE_BITS      (VALUE_BITS),
      .IDX_BITS        (IDX_BITS),
      .CMP_BITS        (CMP_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .wire_idx           (wire_idx),
      .cmp_idx            (cmp_idx),
      .sample_value       (req_sample_value),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_wire_value     (rsp_wire_value),
      .rsp_last_of_vector (rsp_last_of_vector),
      .rsp_is_ascending   (rsp_is_ascending)
   );

   // results only come out of an emit phase
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without a preceding busy cycle");

   // words of one vector are back to back and share the ascending flag
   a_vector_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_vector |=> rsp_valid && $stable(rsp_is_ascending))
      else $error("gap or ascending flag change inside a result vector");

   // the last word closes the vector
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_vector |=> !rsp_valid)
      else $error("result word right after the last word of a vector");

   // nothing is emitted while the controller still takes loads
   a_no_rsp_during_load: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !rsp_valid |=> !rsp_valid)
      else $error("result word straight after a load");

endmodule
`default_nettype wire

// ----- hdl/psn_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psn_ram: generic RAM, one write port and two registered read ports
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module psn_ram #(
   parameter int WIDTH     = 16,
   parameter int DEPTH     = 8,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic [ADDR_BITS-1:0] raddr_a,
   input  wire logic [ADDR_BITS-1:0] raddr_b,
   output logic      [WIDTH-1:0]     rdata_a,
   output logic      [WIDTH-1:0]     rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule
`default_nettype wire

// ----- hdl/psn_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psn_datapath: wire store, comparator table and compare logic
// Holds the CSRs, decodes the current comparator, runs the store reads and
// writes under controller command, and drives the result registers.
// ----------------------------------------------------------------------------
module psn_datapath #(
   parameter int WIRES           = psn_pkg::WIRES_DEF,
   parameter int MAX_COMPARATORS = psn_pkg::MAX_COMPARATORS_DEF,
   parameter int VALUE_BITS      = psn_pkg::VALUE_BITS_DEF,
   parameter int IDX_BITS        = $clog2(WIRES),
   parameter int CMP_BITS        = $clog2(MAX_COMPARATORS + 1)
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire psn_pkg::csr_index_type               csr_index,
   input  wire logic [psn_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  wire psn_pkg::cmd_type                     cmd,
   input  wire logic [IDX_BITS-1:0]                  wire_idx,
   input  wire logic [CMP_BITS-1:0]                  cmp_idx,
   input  wire logic signed [VALUE_BITS-1:0]         sample_value,
   output psn_pkg::status_type                       status,
   output logic                                      rsp_valid,
   output logic signed [VALUE_BITS-1:0]              rsp_wire_value,
   output logic                                      rsp_last_of_vector,
   output logic                                      rsp_is_ascending
);

   import psn_pkg::*;

   logic [COUNT_BITS-1:0]    count_ff;
   logic [CSR_DATA_BITS-1:0] word_ff [CFG_WORDS];
   logic [COUNT_BITS-1:0]    count_sat;
   logic [TABLE_IDX_BITS-1:0] cmp_ext;
   logic [CSR_DATA_BITS-1:0] cur_word;
   logic [PAIR_BITS-1:0]     pair;
   logic [WIRE_FIELD_BITS-1:0] wa, wb, w_lo, w_hi;
   logic [IDX_BITS-1:0]      lo_addr, hi_addr;
   logic                     we;
   logic [IDX_BITS-1:0]      waddr, raddr_a, raddr_b;
   logic [VALUE_BITS-1:0]    wdata, rd_a, rd_b;
   logic [VALUE_BITS-1:0]    hold_ff;
   logic                     chk_ff;
   logic                     asc_ff;
   logic                     valid_ff;
   logic                     last_ff;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < CFG_WORDS; i++) begin
            word_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUNT: count_ff   <= csr_data[COUNT_BITS-1:0];
            CSR_WORD0: word_ff[0] <= csr_data;
            CSR_WORD1: word_ff[1] <= csr_data;
            CSR_WORD2: word_ff[2] <= csr_data;
            default:   ;
         endcase
      end
   end

   // comparator count saturates at the table size
   assign count_sat = (count_ff > COUNT_BITS'(MAX_COMPARATORS)) ?
                      COUNT_BITS'(MAX_COMPARATORS) : count_ff;
   assign cmp_ext   = TABLE_IDX_BITS'(cmp_idx);

   // comparator decode: eight pairs per word
   always_comb begin
      case (cmp_ext[TABLE_IDX_BITS-1:PAIR_SEL_BITS])
         2'd0:    cur_word = word_ff[0];
         2'd1:    cur_word = word_ff[1];
         2'd2:    cur_word = word_ff[2];
         default: cur_word = '0;
      endcase
   end

   assign pair = cur_word[cmp_ext[PAIR_SEL_BITS-1:0] * PAIR_BITS +: PAIR_BITS];
   assign wa   = pair[WIRE_FIELD_BITS-1:0];
   assign wb   = pair[PAIR_BITS-1:WIRE_FIELD_BITS];
   assign w_lo = (wa < wb) ? wa : wb;
   assign w_hi = (wa < wb) ? wb : wa;
   assign lo_addr = w_lo[IDX_BITS-1:0];
   assign hi_addr = w_hi[IDX_BITS-1:0];

   // out-of-range wire or a repeated wire leaves the vector alone
   assign status.pair_ok  = (int'(w_hi) < WIRES) && (w_lo != w_hi);
   assign status.net_done = (cmp_ext >= count_sat);
   assign status.greater  = ($signed(rd_a) > $signed(rd_b));

   // store write port
   always_comb begin
      we    = 1'b1;
      waddr = wire_idx;
      wdata = sample_value;
      case (cmd.wr_sel)
         WR_NONE: we = 1'b0;
         WR_LOAD: begin
            waddr = wire_idx;
            wdata = sample_value;
         end
         WR_LOW: begin
            waddr = lo_addr;
            wdata = rd_b;
         end
         WR_HIGH: begin
            waddr = hi_addr;
            wdata = hold_ff;
         end
         default: we = 1'b0;
      endcase
   end

   // store read addresses
   always_comb begin
      case (cmd.rd_sel)
         RD_PAIR: begin
            raddr_a = lo_addr;
            raddr_b = hi_addr;
         end
         RD_ADJ: begin
            raddr_a = wire_idx;
            raddr_b = IDX_BITS'(wire_idx + 1'b1);
         end
         RD_WIRE: begin
            raddr_a = wire_idx;
            raddr_b = wire_idx;
         end
         default: begin
            raddr_a = wire_idx;
            raddr_b = wire_idx;
         end
      endcase
   end

   psn_ram #(
      .WIDTH     (VALUE_BITS),
      .DEPTH     (WIRES),
      .ADDR_BITS (IDX_BITS)
   ) u_store (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   // upper value of a swapping pair, written back on the next cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_sel == WR_LOW) begin
         hold_ff <= rd_a;
      end
   end

   // ascending check: one adjacent pair per cycle, each compared in the cycle after its read
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff <= 1'b0;
         asc_ff <= 1'b1;
      end else begin
         chk_ff <= cmd.asc_check;
         if (cmd.asc_init) begin
            asc_ff <= 1'b1;
         end else if (chk_ff && status.greater) begin
            asc_ff <= 1'b0;
         end
      end
   end

   // result strobe comes in the cycle after the emit read
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
         last_ff  <= cmd.emit_last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_wire_value     = $signed(rd_a);
   assign rsp_last_of_vector = last_ff;
   assign rsp_is_ascending   = asc_ff;

endmodule
`default_nettype wire

// ----- hdl/psn_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psn_ctrl: sequencer for load, network, ascending check and emit phases
// Owns the wire counter and the comparator counter and issues one command
// word per cycle to the datapath.
// ----------------------------------------------------------------------------
module psn_ctrl #(
   parameter int WIRES           = psn_pkg::WIRES_DEF,
   parameter int MAX_COMPARATORS = psn_pkg::MAX_COMPARATORS_DEF,
   parameter int IDX_BITS        = $clog2(WIRES),
   parameter int CMP_BITS        = $clog2(MAX_COMPARATORS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire psn_pkg::status_type  status,
   output logic                      busy,
   output psn_pkg::cmd_type          cmd,
   output logic [IDX_BITS-1:0]       wire_idx,
   output logic [CMP_BITS-1:0]       cmp_idx
);

   import psn_pkg::*;

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [CMP_BITS-1:0] cmp_ff, cmp_in;
   logic                idx_top, idx_adj_top;

   assign idx_top     = (idx_ff == IDX_BITS'(WIRES - 1));
   assign idx_adj_top = (idx_ff == IDX_BITS'(WIRES - 2));

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         idx_ff   <= '0;
         cmp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cmp_ff   <= cmp_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmp_in        = cmp_ff;
      busy          = 1'b1;
      cmd.wr_sel    = WR_NONE;
      cmd.rd_sel    = RD_PAIR;
      cmd.asc_init  = 1'b0;
      cmd.asc_check = 1'b0;
      cmd.emit      = 1'b0;
      cmd.emit_last = 1'b0;
      case (state_ff)
         // take one word per start; the last wire kicks off the network
         ST_LOAD: begin
            busy = 1'b0;
            if (start) begin
               cmd.wr_sel = WR_LOAD;
               if (idx_top) begin
                  idx_in   = '0;
                  cmp_in   = '0;
                  state_in = ST_NET_ISSUE;
               end else begin
                  idx_in = IDX_BITS'(idx_ff + 1'b1);
               end
            end
         end
         // read the pair of the current comparator, skip dead ones, start the ascending check when done
         ST_NET_ISSUE: begin
            cmd.rd_sel = RD_PAIR;
            if (status.net_done) begin
               cmd.asc_init = 1'b1;
               idx_in       = '0;
               state_in     = ST_ASC_RUN;
            end else if (!status.pair_ok) begin
               cmp_in = CMP_BITS'(cmp_ff + 1'b1);
            end else begin
               state_in = ST_NET_CMP;
            end
         end
         // pair data is back: write the minimum low if out of order
         ST_NET_CMP: begin
            cmd.rd_sel = RD_PAIR;
            if (status.greater) begin
               cmd.wr_sel = WR_LOW;
               state_in   = ST_NET_SWAP;
            end else begin
               cmp_in   = CMP_BITS'(cmp_ff + 1'b1);
               state_in = ST_NET_ISSUE;
            end
         end
         // write the maximum high
         ST_NET_SWAP: begin
            cmd.rd_sel = RD_PAIR;
            cmd.wr_sel = WR_HIGH;
            cmp_in     = CMP_BITS'(cmp_ff + 1'b1);
            state_in   = ST_NET_ISSUE;
         end
         // stream adjacent pairs through the compare
         ST_ASC_RUN: begin
            cmd.rd_sel    = RD_ADJ;
            cmd.asc_check = 1'b1;
            if (idx_adj_top) begin
               state_in = ST_ASC_LAST;
            end else begin
               idx_in = IDX_BITS'(idx_ff + 1'b1);
            end
         end
         // last adjacent compare lands here
         ST_ASC_LAST: begin
            cmd.rd_sel = RD_WIRE;
            idx_in     = '0;
            state_in   = ST_EMIT;
         end
         // read wires in order, one result per cycle
         ST_EMIT: begin
            cmd.rd_sel    = RD_WIRE;
            cmd.emit      = 1'b1;
            cmd.emit_last = idx_top;
            if (idx_top) begin
               idx_in   = '0;
               state_in = ST_LOAD;
            end else begin
               idx_in = IDX_BITS'(idx_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_LOAD;
            idx_in   = '0;
         end
      endcase
   end

   assign wire_idx = idx_ff;
   assign cmp_idx  = cmp_ff;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: programmable sorting network
// Loads vectors of signed words through the start/busy port and programs the
// comparator table over the CSR channel. Each result word is checked against
// an in-bench compare-exchange model of the configured network.
// ----------------------------------------------------------------------------
module testbench;
   import psn_pkg::*;

   localparam int NUM_WIRES        = WIRES_DEF;
   localparam int MAX_CMP          = MAX_COMPARATORS_DEF;
   localparam int VB               = VALUE_BITS_DEF;
   localparam int PAIRS_PER_WORD   = CSR_DATA_BITS / PAIR_BITS;
   localparam int DRAIN_CYCLES     = 110;
   localparam int STALL_LIMIT      = 2000;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int RANDOM_PHASES    = 8;
   localparam int VECTORS_PER_PHASE = 7;

   typedef logic signed [VB-1:0] sample_type;

   typedef struct packed {
      sample_type value;
      logic       last;
      logic       ascending;
   } wire_word_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     start            = 1'b0;
   logic                     busy;
   sample_type               req_sample_value = '0;
   logic                     rsp_valid;
   sample_type               rsp_wire_value;
   logic                     rsp_last_of_vector;
   logic                     rsp_is_ascending;
   logic                     csr_valid        = 1'b0;
   logic                     csr_ready;
   csr_index_type            csr_index        = CSR_COUNT;
   logic [CSR_DATA_BITS-1:0] csr_data         = '0;

   // network model: programmed table and the vector being loaded
   logic [COUNT_BITS-1:0]    cmp_count = '0;
   logic [CSR_DATA_BITS-1:0] cmp_words [CFG_WORDS] = '{default: '0};
   logic [PAIR_BITS-1:0]     cmp_slots [MAX_CMP];
   sample_type               vector_store [NUM_WIRES];
   int                       load_index = 0;
   wire_word_type            sorted_words_q [$];

   int                       mismatch_count = 0;
   int                       stall_cycles   = 0;
   bit                       burst_mode     = 1'b0;

   programmable_sorting_network dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_sample_value   (req_sample_value),
      .rsp_valid          (rsp_valid),
      .rsp_wire_value     (rsp_wire_value),
      .rsp_last_of_vector (rsp_last_of_vector),
      .rsp_is_ascending   (rsp_is_ascending),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #10 clock = ~clock;

   // compare-exchange pass over the full vector, then queue the result words
   task automatic apply_network();
      int unsigned              used;
      int unsigned              a;
      int unsigned              b;
      int unsigned              lo;
      int unsigned              hi;
      logic [CSR_DATA_BITS-1:0] shifted;
      logic [PAIR_BITS-1:0]     pair;
      sample_type               held;
      logic                     ascending;
      wire_word_type            word;
      used = (cmp_count > MAX_CMP) ? MAX_CMP : cmp_count;
      for (int unsigned k = 0; k < used; k++) begin
         shifted = cmp_words[k / PAIRS_PER_WORD] >> (PAIR_BITS * (k % PAIRS_PER_WORD));
         pair    = shifted[PAIR_BITS-1:0];
         a       = pair[WIRE_FIELD_BITS-1:0];
         b       = pair[PAIR_BITS-1:WIRE_FIELD_BITS];
         lo      = (a < b) ? a : b;
         hi      = (a < b) ? b : a;
         // out-of-range and same-wire comparators are no-ops
         if (hi < NUM_WIRES && lo != hi && vector_store[lo] > vector_store[hi]) begin
            held             = vector_store[lo];
            vector_store[lo] = vector_store[hi];
            vector_store[hi] = held;
         end
      end
      ascending = 1'b1;
      for (int i = 0; i + 1 < NUM_WIRES; i++)
         if (vector_store[i] > vector_store[i+1])
            ascending = 1'b0;
      for (int i = 0; i < NUM_WIRES; i++) begin
         word.value     = vector_store[i];
         word.last      = (i == NUM_WIRES - 1);
         word.ascending = ascending;
         sorted_words_q.push_back(word);
      end
   endtask

   // present one word on the input port; start stays high after the handshake
   task automatic send_sample(input sample_type value);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 4);
      csr_valid <= 1'b0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_sample_value <= value;
      do @(posedge clock); while (busy);
      vector_store[load_index] = value;
      load_index++;
      if (load_index == NUM_WIRES) begin
         load_index = 0;
         apply_network();
      end
   endtask

   // one CSR write; valid stays high after the handshake
   task automatic write_csr(input csr_index_type index,
                            input logic [CSR_DATA_BITS-1:0] value);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 4);
      start <= 1'b0;
      if (gap != 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_COUNT: cmp_count    = value[COUNT_BITS-1:0];
         CSR_WORD0: cmp_words[0] = value;
         CSR_WORD1: cmp_words[1] = value;
         CSR_WORD2: cmp_words[2] = value;
         default: ;
      endcase
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pack_slots(input int w);
      logic [CSR_DATA_BITS-1:0] word;
      for (int s = 0; s < PAIRS_PER_WORD; s++)
         word[s*PAIR_BITS +: PAIR_BITS] = cmp_slots[w*PAIRS_PER_WORD + s];
      return word;
   endfunction

   task automatic load_comparator_table();
      write_csr(CSR_WORD0, pack_slots(0));
      write_csr(CSR_WORD1, pack_slots(1));
      write_csr(CSR_WORD2, pack_slots(2));
   endtask

   // drop both valids, wait out every pending result, then let the block go idle
   task automatic settle();
      start     <= 1'b0;
      csr_valid <= 1'b0;
      while (sorted_words_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // reset table: no comparators, vector comes back as loaded
   task automatic test_table_empty();
      sample_type vals [NUM_WIRES] = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001,
                                       16'sh0001, -16'sh8000, 16'sh7FFF, 16'sh0000};
      foreach (vals[i]) send_sample(vals[i]);
      settle();
   endtask

   // odd-even merge sorter, pads as same-wire pairs, count written mid-vector
   task automatic test_merge_network();
      int unsigned lo_wire [19] = '{0,2,4,6,0,1,4,5,1,5,0,1,2,3,2,3,1,3,5};
      int unsigned hi_wire [19] = '{1,3,5,7,2,3,6,7,2,6,4,5,6,7,4,5,2,4,6};
      sample_type  falling [NUM_WIRES] = '{16'sh7FFF, 16'sh03E8, 16'sh0001, 16'sh0000,
                                           -16'sh0001, -16'sh03E8, -16'sh7FFF, -16'sh8000};
      sample_type  repeats [NUM_WIRES] = '{16'sh0005, -16'sh0003, 16'sh0005, -16'sh8000,
                                           16'sh0000, -16'sh0003, 16'sh7FFF, -16'sh8000};
      logic [CSR_DATA_BITS-1:0] count_data;
      for (int k = 0; k < MAX_CMP; k++) begin
         if (k < 19)
            // odd slots list the pair upper wire first
            cmp_slots[k] = k[0] ? {lo_wire[k][2:0], hi_wire[k][2:0]}
                                : {hi_wire[k][2:0], lo_wire[k][2:0]};
         else
            cmp_slots[k] = {k[2:0], k[2:0]};
      end
      write_csr(CSR_COUNT, '0);
      load_comparator_table();
      for (int i = 0; i < NUM_WIRES / 2; i++) send_sample(falling[i]);
      // count above the table size saturates; upper data bits are ignored
      count_data = CSR_DATA_BITS'({$urandom, $urandom});
      count_data[COUNT_BITS-1:0] = '1;
      write_csr(CSR_COUNT, count_data);
      for (int i = NUM_WIRES / 2; i < NUM_WIRES; i++) send_sample(falling[i]);
      settle();
      write_csr(CSR_COUNT, CSR_DATA_BITS'(19));
      foreach (repeats[i]) send_sample(repeats[i]);
      settle();
   endtask

   // random tables and counts, with fixed ones in some phases, several vector shapes per phase
   task automatic test_random_networks();
      logic [CSR_DATA_BITS-1:0] count_data;
      int                       style;
      int                       level;
      sample_type               value;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         burst_mode = (phase % 3 == 1);
         count_data = CSR_DATA_BITS'({$urandom, $urandom});
         case (phase)
            0:       count_data[COUNT_BITS-1:0] = '0;
            1:       count_data[COUNT_BITS-1:0] = COUNT_BITS'(MAX_CMP);
            2:       count_data[COUNT_BITS-1:0] = '1;
            default: ;
         endcase
         for (int k = 0; k < MAX_CMP; k++) begin
            case (phase)
               3:       cmp_slots[k] = '1;
               4:       cmp_slots[k] = '0;
               default: cmp_slots[k] = PAIR_BITS'($urandom);
            endcase
         end
         write_csr(CSR_COUNT, count_data);
         load_comparator_table();
         for (int v = 0; v < VECTORS_PER_PHASE; v++) begin
            style = $urandom_range(0, 3);
            level = -32768 + int'($urandom_range(0, 30000));
            for (int i = 0; i < NUM_WIRES; i++) begin
               case (style)
                  0: value = sample_type'($urandom);
                  1: value = sample_type'(int'($urandom_range(0, 8)) - 4);
                  2: case ($urandom_range(0, 3))
                        0:       value = -16'sh8000;
                        1:       value = 16'sh7FFF;
                        2:       value = 16'sh0000;
                        default: value = -16'sh0001;
                     endcase
                  default: begin
                     // nondecreasing run
                     value = sample_type'(level);
                     level = level + int'($urandom_range(0, 4000));
                     if (level > 32767) level = 32767;
                  end
               endcase
               send_sample(value);
            end
         end
         settle();
      end
      burst_mode = 1'b0;
   endtask

   // result checker: every strobed word against the oldest expectation
   always @(posedge clock) begin : check_results
      wire_word_type want;
      if (!reset && rsp_valid) begin
         if (sorted_words_q.size() == 0) begin
            if (mismatch_count < SHOWN_MISMATCHES)
               $display("unexpected result word: value %0d last %b asc %b",
                        rsp_wire_value, rsp_last_of_vector, rsp_is_ascending);
            mismatch_count++;
         end else begin
            want = sorted_words_q.pop_front();
            if (rsp_wire_value !== want.value || rsp_last_of_vector !== want.last ||
                rsp_is_ascending !== want.ascending) begin
               if (mismatch_count < SHOWN_MISMATCHES)
                  $display("result mismatch: expected %0d/%b/%b, got %0d/%b/%b",
                           $signed(want.value), want.last, want.ascending,
                           rsp_wire_value, rsp_last_of_vector, rsp_is_ascending);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_empty();
      test_merge_network();
      test_random_networks();
      settle();
      if (mismatch_count == 0 && sorted_words_q.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
